>>> rtl/qpe_pkg.sv
// Shared types, character constants and helpers for the quoted-printable encoder.
`default_nettype none
package qpe_pkg;
	localparam logic [7:0] CHAR_PRINT_LO = 8'd33;   // '!'
	localparam logic [7:0] CHAR_PRINT_HI = 8'd126;  // '~'
	localparam logic [7:0] CHAR_EQ       = 8'h3D;   // '='
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [7:0] CHAR_LF       = 8'h0A;
	localparam logic [9:0] BREAK_MARGIN  = 10'd3;
	localparam logic [7:0] MAX_LEN_RESET = 8'd78;

	// One classified byte handed from the front part to the back part.
	typedef struct packed {
		logic [7:0] data;
		logic       esc;  // emit as '=' and two hex digits
		logic       brk;  // append soft break '=', CR, LF
	} qpe_cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h37 + {4'd0, nib};
		end
		return c;
	endfunction
endpackage
`default_nettype wire

>>> rtl/qpe_front.sv
// Front part: accept raw bytes, classify them and track the line length.
`default_nettype none
module qpe_front
	import qpe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] max_len,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tlast,   // last_in_message
	input  wire logic       push_ready,
	output logic            push_valid,
	output qpe_cmd_t        push_cmd
);
	logic [7:0] line_count_q;
	logic       esc;
	logic [8:0] sum;
	logic       brk;

	assign esc = !(s_axis_tdata >= CHAR_PRINT_LO && s_axis_tdata <= CHAR_PRINT_HI &&
		s_axis_tdata != CHAR_EQ);
	assign sum = {1'b0, line_count_q} + (esc ? 9'd3 : 9'd1);
	// count >= max_len - 3, kept unsigned by moving the margin to the left side
	assign brk = ({1'b0, sum} + BREAK_MARGIN) >= {2'b00, max_len};

	assign s_axis_tready = push_ready;
	assign push_valid    = s_axis_tvalid;
	assign push_cmd      = '{data: s_axis_tdata, esc: esc, brk: brk};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
		end else if (s_axis_tvalid && push_ready) begin
			if (brk || s_axis_tlast) begin
				line_count_q <= '0;
			end else begin
				line_count_q <= sum[7:0];
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/qpe_queue.sv
// Short first-word-fall-through queue between the front and back parts.
`default_nettype none
module qpe_queue
	import qpe_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire qpe_cmd_t push_cmd,
	output logic          pop_valid,
	input  wire logic     pop,
	output qpe_cmd_t      pop_cmd
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	qpe_cmd_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != FULL_CNT;
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/qpe_back.sv
// Back part: expand each classified byte into output characters, one per cycle unless the output is stalled.
`default_nettype none
module qpe_back
	import qpe_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	input  wire qpe_cmd_t cmd,
	output logic          cmd_pop,
	output logic          m_axis_tvalid,
	input  wire logic     m_axis_tready,
	output logic [7:0]    m_axis_tdata,   // [7:0] out_char
	output logic          m_axis_tlast    // last_of_run
);
	logic [2:0] step_q;
	logic [2:0] base;
	logic [2:0] total;
	logic [2:0] brk_pos;
	logic [7:0] chr;
	logic       is_last;
	logic       load;
	logic [7:0] tdata_q;
	logic       tlast_q;
	logic       tvalid_q;

	assign base    = cmd.esc ? 3'd3 : 3'd1;
	assign total   = base + (cmd.brk ? 3'd3 : 3'd0);
	assign brk_pos = step_q - base;
	assign is_last = step_q == (total - 3'd1);
	assign load    = cmd_valid && (!tvalid_q || m_axis_tready);
	assign cmd_pop = load && is_last;

	always_comb begin
		chr = CHAR_EQ;
		if (step_q < base) begin
			if (!cmd.esc) begin
				chr = cmd.data;
			end else begin
				case (step_q[1:0])
					2'd1:    chr = hex_char(cmd.data[7:4]);
					2'd2:    chr = hex_char(cmd.data[3:0]);
					default: chr = CHAR_EQ;
				endcase
			end
		end else begin
			case (brk_pos[1:0])
				2'd1:    chr = CHAR_CR;
				2'd2:    chr = CHAR_LF;
				default: chr = CHAR_EQ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= chr;
			tlast_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			step_q   <= '0;
		end else begin
			if (load) begin
				tvalid_q <= 1'b1;
				step_q   <= is_last ? 3'd0 : step_q + 3'd1;
			end else if (m_axis_tready) begin
				// drop the word once taken
				tvalid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;
endmodule
`default_nettype wire

>>> rtl/quoted_printable_encoder.sv
// Quoted-printable encoder: front classifier, command queue, character generator.
// Each byte passes through the queue, and its characters through the back part's output register.
// Output: one character per cycle from the output register while m_axis_tready is high; a byte
// expands to 1 to 6 characters (1 or 3 for the byte, plus 3 for a soft break) in the back part.
// The queue lets bytes be accepted while earlier ones are still being expanded.
// Reset clears the line count, queue and output valid; max_line_length returns to 78.
`default_nettype none
module quoted_printable_encoder
	import qpe_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,       // max_line_length
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tlast,   // last_in_message
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_char
	output logic            m_axis_tlast    // last_of_run
);
	logic [7:0] max_len_q;
	logic       push_valid;
	logic       push_ready;
	qpe_cmd_t   push_cmd;
	logic       pop_valid;
	logic       pop;
	qpe_cmd_t   pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	qpe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_len       (max_len_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.push_ready    (push_ready),
		.push_valid    (push_valid),
		.push_cmd      (push_cmd)
	);

	qpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	qpe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (pop_valid),
		.cmd           (pop_cmd),
		.cmd_pop       (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);
endmodule
`default_nettype wire
